>>> src/mt64_pkg.sv
// Package: constants, state type and tempering function of the 64-bit twister generator.
package mt64_pkg;

    localparam int TableWords   = 312;
    localparam int MiddleOffset = 156;

    localparam logic [63:0] InitMult    = 64'd6364136223846793005;
    localparam logic [63:0] TwistMatrix = 64'hB5026F5AA96619E9;
    localparam logic [63:0] UpperMask   = 64'hFFFFFFFF80000000;
    localparam logic [63:0] LowerMask   = 64'h000000007FFFFFFF;
    localparam logic [63:0] TemperD     = 64'h5555555555555555;
    localparam logic [63:0] TemperB     = 64'h71D67FFFEDA60000;
    localparam logic [63:0] TemperC     = 64'hFFF7EEE000000000;

    localparam logic OpSeed = 1'b0;
    localparam logic OpDraw = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SD_M0,
        ST_SD_M1,
        ST_SD_M2,
        ST_SD_M3,
        ST_TW_RD0,
        ST_TW_RD1,
        ST_TW_RD2,
        ST_TW_WAIT,
        ST_TW_WR,
        ST_DR_RD,
        ST_DR_WAIT,
        ST_DIV,
        ST_FIN
    } t_state;

    function automatic logic [63:0] temper(input logic [63:0] w_in);
        logic [63:0] w;
        w = w_in;
        w = w ^ ((w >> 29) & TemperD);
        w = w ^ ((w << 17) & TemperB);
        w = w ^ ((w << 37) & TemperC);
        w = w ^ (w >> 43);
        return w;
    endfunction

endpackage

>>> src/mt64_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
module mt64_ram #(
    parameter int Width = 64,
    parameter int Depth = 312
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/mt64_range_random_generator.sv
// Top level: 64-bit Mersenne twister with ranged output, table held in one RAM.
//
// Use: drive i_op and the payload ports and raise start; a beat is taken at a
// rising edge where start is high and busy is low. A seed beat (op 0) fills
// the 312-word table from i_seed_value, one word at a time through a shared
// 32x32 multiplier, and gives no result. A draw beat (op 1) gives one
// result: o_valid is high for one cycle with o_value and o_not_seeded. A
// draw before any seed answers in the next cycle with value zero and
// o_not_seeded set. Otherwise the draw reads the next table word, tempers
// it and reduces it modulo the span with a restoring divider, one quotient
// bit per cycle. The first draw after a seed, and every 312th draw after
// it, first regenerates the whole table through the single RAM read port.
// A span that wraps to zero skips the divider. Reset clears the seeded flag
// and sets the read position to the end of the table; the table contents
// stay undefined until a seed writes them. The receiver cannot stall: a
// result is shown once and busy drops in the same cycle.
module mt64_range_random_generator #(
    parameter int TABLE_WORDS   = mt64_pkg::TableWords,
    parameter int MIDDLE_OFFSET = mt64_pkg::MiddleOffset
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [63:0] i_seed_value,
    input  logic signed [63:0] i_range_min,
    input  logic signed [63:0] i_range_max,
    output logic        o_valid,
    output logic signed [63:0] o_value,
    output logic        o_not_seeded
);

    localparam int AW = $clog2(TABLE_WORDS);
    localparam int PW = $clog2(TABLE_WORDS + 1);
    localparam logic [AW-1:0] LastIdx = AW'(TABLE_WORDS - 1);
    localparam logic [AW-1:0] MidIdx  = AW'(MIDDLE_OFFSET);
    localparam logic [AW-1:0] BackOff = AW'(TABLE_WORDS - MIDDLE_OFFSET);
    localparam logic [PW-1:0] EndPos  = PW'(TABLE_WORDS);

    mt64_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_pos;
    logic          r_seeded;
    logic [AW-1:0] r_k;
    logic [63:0]   r_prev, r_acc, r_prod, r_a, r_b;
    logic [63:0]   r_lo, r_span, r_rem, r_quo;
    logic [5:0]    r_cnt;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;

    logic          accept;
    logic [63:0]   x_seed, seed_word, twist_word, y_mix, tempered;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   mul_p;
    logic [AW-1:0] k_next, k_far;
    logic [64:0]   rem_sh, rem_diff;

    mt64_ram #(
        .Width (64),
        .Depth (TABLE_WORDS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept = start && (r_state == mt64_pkg::ST_IDLE);
    assign busy   = (r_state != mt64_pkg::ST_IDLE);

    // Seed recurrence operand, and one shared 32x32 multiplier.
    assign x_seed = r_prev ^ (r_prev >> 62);
    always_comb begin
        mul_a = x_seed[31:0];
        mul_b = mt64_pkg::InitMult[31:0];
        case (r_state)
            mt64_pkg::ST_SD_M1: mul_a = x_seed[63:32];
            mt64_pkg::ST_SD_M2: mul_b = mt64_pkg::InitMult[63:32];
            default: ;
        endcase
    end
    assign mul_p     = 64'(mul_a) * 64'(mul_b);
    assign seed_word = r_acc + {r_prod[31:0], 32'd0} + 64'(r_k);

    // Twist neighbours.
    assign k_next = (r_k == LastIdx) ? '0 : r_k + AW'(1);
    assign k_far  = (r_k < BackOff) ? r_k + MidIdx : r_k - BackOff;
    assign y_mix  = (r_a & mt64_pkg::UpperMask) | (r_b & mt64_pkg::LowerMask);
    assign twist_word = ram_rdata ^ (y_mix >> 1) ^
                        (y_mix[0] ? mt64_pkg::TwistMatrix : 64'd0);

    assign tempered = mt64_pkg::temper(ram_rdata);

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign rem_sh   = {r_rem, r_quo[63]};
    assign rem_diff = rem_sh - {1'b0, r_span};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = seed_word;
        ram_raddr = r_k;
        case (r_state)
            mt64_pkg::ST_IDLE: begin
                // Seed word zero goes straight in.
                ram_we    = accept && (i_op == mt64_pkg::OpSeed);
                ram_waddr = '0;
                ram_wdata = i_seed_value;
            end
            mt64_pkg::ST_SD_M3:  ram_we = 1'b1;
            mt64_pkg::ST_TW_RD1: ram_raddr = k_next;
            mt64_pkg::ST_TW_RD2, mt64_pkg::ST_TW_WAIT: ram_raddr = k_far;
            mt64_pkg::ST_TW_WR: begin
                ram_we    = 1'b1;
                ram_wdata = twist_word;
            end
            mt64_pkg::ST_DR_RD:  ram_raddr = r_pos[AW-1:0];
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mt64_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_op == mt64_pkg::OpSeed) begin
                        n_state = mt64_pkg::ST_SD_M0;
                    end else if (r_seeded) begin
                        n_state = (r_pos == EndPos) ? mt64_pkg::ST_TW_RD0
                                                    : mt64_pkg::ST_DR_RD;
                    end
                end
            end
            mt64_pkg::ST_SD_M0: n_state = mt64_pkg::ST_SD_M1;
            mt64_pkg::ST_SD_M1: n_state = mt64_pkg::ST_SD_M2;
            mt64_pkg::ST_SD_M2: n_state = mt64_pkg::ST_SD_M3;
            mt64_pkg::ST_SD_M3: n_state = (r_k == LastIdx) ? mt64_pkg::ST_IDLE
                                                           : mt64_pkg::ST_SD_M0;
            mt64_pkg::ST_TW_RD0:  n_state = mt64_pkg::ST_TW_RD1;
            mt64_pkg::ST_TW_RD1:  n_state = mt64_pkg::ST_TW_RD2;
            mt64_pkg::ST_TW_RD2:  n_state = mt64_pkg::ST_TW_WAIT;
            mt64_pkg::ST_TW_WAIT: n_state = mt64_pkg::ST_TW_WR;
            mt64_pkg::ST_TW_WR:   n_state = (r_k == LastIdx) ? mt64_pkg::ST_DR_RD
                                                             : mt64_pkg::ST_TW_RD0;
            mt64_pkg::ST_DR_RD:   n_state = mt64_pkg::ST_DR_WAIT;
            mt64_pkg::ST_DR_WAIT: n_state = (r_span == 64'd0) ? mt64_pkg::ST_IDLE
                                                             : mt64_pkg::ST_DIV;
            mt64_pkg::ST_DIV:     n_state = (r_cnt == 6'd63) ? mt64_pkg::ST_FIN
                                                            : mt64_pkg::ST_DIV;
            mt64_pkg::ST_FIN:     n_state = mt64_pkg::ST_IDLE;
            default:              n_state = mt64_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mt64_pkg::ST_IDLE;
            r_pos    <= EndPos;
            r_seeded <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            case (r_state)
                mt64_pkg::ST_IDLE: begin
                    if (accept && (i_op == mt64_pkg::OpDraw) && !r_seeded) begin
                        o_valid <= 1'b1;
                    end
                end
                mt64_pkg::ST_SD_M3: begin
                    if (r_k == LastIdx) begin
                        r_pos    <= EndPos;
                        r_seeded <= 1'b1;
                    end
                end
                mt64_pkg::ST_TW_WR: begin
                    if (r_k == LastIdx) begin
                        r_pos <= '0;
                    end
                end
                mt64_pkg::ST_DR_WAIT: begin
                    r_pos <= r_pos + PW'(1);
                    if (r_span == 64'd0) begin
                        o_valid <= 1'b1;
                    end
                end
                mt64_pkg::ST_FIN: o_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            mt64_pkg::ST_IDLE: begin
                r_prev       <= i_seed_value;
                r_k          <= (i_op == mt64_pkg::OpSeed) ? AW'(1) : '0;
                r_lo         <= i_range_min;
                r_span       <= i_range_max - i_range_min + 64'd1;
                o_value      <= '0;
                o_not_seeded <= 1'b1;
            end
            mt64_pkg::ST_SD_M1: r_acc <= r_prod;
            mt64_pkg::ST_SD_M2: r_acc <= r_acc + {r_prod[31:0], 32'd0};
            mt64_pkg::ST_SD_M3: begin
                r_prev <= seed_word;
                r_k    <= r_k + AW'(1);
            end
            mt64_pkg::ST_TW_RD1:  r_a <= ram_rdata;
            mt64_pkg::ST_TW_RD2:  r_b <= ram_rdata;
            mt64_pkg::ST_TW_WR:   r_k <= k_next;
            mt64_pkg::ST_DR_WAIT: begin
                r_rem        <= '0;
                r_quo        <= tempered;
                r_cnt        <= '0;
                o_value      <= r_lo + tempered;
                o_not_seeded <= 1'b0;
            end
            mt64_pkg::ST_DIV: begin
                r_rem <= rem_diff[64] ? rem_sh[63:0] : rem_diff[63:0];
                r_quo <= {r_quo[62:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
            end
            mt64_pkg::ST_FIN: begin
                o_value      <= r_lo + r_rem;
                o_not_seeded <= 1'b0;
            end
            default: ;
        endcase
    end

endmodule

>>> src/mt64_checker.sv
// Checker on the top level ports of the twister generator, bound to the top level.
module mt64_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_op,
    input logic        o_valid,
    input logic [63:0] o_value,
    input logic        o_not_seeded
);

    a_unseeded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_seeded |-> o_value == 64'd0)
        else $error("unseeded result carries a non-zero value");

    a_unseeded_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_not_seeded |-> $past(start && !busy && i_op == mt64_pkg::OpDraw))
        else $error("unseeded result without a draw beat the cycle before");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_seed_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op == mt64_pkg::OpSeed |=> busy && !o_valid)
        else $error("seed beat did not start the table fill");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("activity right after reset");

endmodule

bind mt64_range_random_generator mt64_checker u_mt64_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_op         (i_op),
    .o_valid      (o_valid),
    .o_value      (o_value),
    .o_not_seeded (o_not_seeded)
);
